FILE: src/dqprt_pkg.sv
package dqprt_pkg;

    // Packet descriptor as held in each direction queue
    typedef struct packed {
        logic [2:0]  retries;
        logic [2:0]  priority_val;
        logic [10:0] size;
        logic [15:0] id;
    } desc_t;

    typedef enum logic [2:0] {
        ST_QUEUED      = 3'd0,
        ST_OVERFLOW    = 3'd1,
        ST_SENT        = 3'd2,
        ST_REQUEUED    = 3'd3,
        ST_RETRY_DROP  = 3'd4,
        ST_REQUEUE_OVF = 3'd5,
        ST_IDLE        = 3'd6
    } status_t;

    typedef enum logic {
        CMD_ENQUEUE = 1'b0,
        CMD_SERVICE = 1'b1
    } cmd_t;

    localparam logic CFG_BUFFER_LIMIT = 1'b0;
    localparam logic CFG_MAX_RETRIES  = 1'b1;

    localparam logic [4:0] BUFFER_LIMIT_RESET = 5'd10;
    localparam logic [2:0] MAX_RETRIES_RESET  = 3'd3;

    // Requests from the scheduler to one queue
    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

    // Occupancy flags of one queue, checked against the buffer limit
    typedef struct packed {
        logic nonempty;
        logic full;
        logic full_after_pop;
    } q_stat_t;

endpackage

FILE: src/dual_queue_priority_retransmit_unit.sv
// Two-queue strict-priority transmit scheduler with a retry limit.
// Requests arrive on the s_ channel: s_tuser selects enqueue (0) or service (1),
// s_tdata carries the descriptor, direction, initial retry count and the
// lost-slot flag. Every request gives exactly one result on the m_ channel:
// m_tuser holds the status code, m_tdata the packet concerned and the sent count.
// Service pops the uplink queue first, then downlink; a lost slot requeues the
// packet with a raised retry count until max_retries is reached.
// Configuration: cfg_index 0 writes buffer_limit, 1 writes max_retries; write
// only while no request is in flight. cfg_ready is always high.
// The request sits in the input register, and its outcome then lands in the result
// register that drives the m_ channel. Throughput: one request per cycle while
// m_tready is high, set by the combinational push/pop decision and the
// registered head prefetch from each queue's RAM.
// Reset (aresetn low, synchronous) empties both queues, clears the sent count
// and loads buffer_limit 10 and max_retries 3.
// While a result waits with m_tready low the result register holds; the input register still
// takes one more request and then s_tready drops until the result is taken.
module dual_queue_priority_retransmit_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // pkt_id[15:0], pkt_size[26:16], pkt_priority[29:27],
                                   // is_uplink[30], retry_in[33:31], slot_lost[34], zero pad
    input  logic [0:0]  s_tuser,   // cmd[0]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_id[15:0], out_size[26:16], out_priority[29:27],
                                   // out_uplink[30], out_retries[33:31],
                                   // sent_count[49:34], zero pad
    output logic [2:0]  m_tuser,   // status[2:0]
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [4:0]  cfg_data
);

    // input register
    logic             in_valid_reg;
    logic             cmd_reg;
    dqprt_pkg::desc_t in_desc_reg;
    logic             in_uplink_reg;
    logic             in_lost_reg;

    // result register
    logic              out_valid_reg;
    dqprt_pkg::status_t out_status_reg;
    dqprt_pkg::desc_t  out_desc_reg;
    logic              out_uplink_reg;

    logic [4:0]  buffer_limit_reg;
    logic [2:0]  max_retries_reg;
    logic [15:0] sent_reg, sent_next;

    logic advance, fire, s_accept;

    dqprt_pkg::q_ctrl_t up_ctrl, dn_ctrl;
    dqprt_pkg::q_stat_t up_stat, dn_stat;
    dqprt_pkg::desc_t   up_head, dn_head;
    dqprt_pkg::desc_t   push_desc;

    dqprt_pkg::status_t res_status;
    dqprt_pkg::desc_t   res_desc;
    logic               res_uplink;

    assign advance   = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        dqprt_pkg::desc_t hd;
        logic             pick_up;
        logic             room;

        up_ctrl    = '0;
        dn_ctrl    = '0;
        push_desc  = in_desc_reg;
        res_status = dqprt_pkg::ST_IDLE;
        res_desc   = '0;
        res_uplink = 1'b0;
        sent_next  = sent_reg;
        pick_up    = up_stat.nonempty;
        hd         = pick_up ? up_head : dn_head;
        room       = 1'b0;

        unique case (dqprt_pkg::cmd_t'(cmd_reg))
            dqprt_pkg::CMD_ENQUEUE: begin
                room       = in_uplink_reg ? !up_stat.full : !dn_stat.full;
                res_desc   = in_desc_reg;
                res_uplink = in_uplink_reg;
                res_status = room ? dqprt_pkg::ST_QUEUED : dqprt_pkg::ST_OVERFLOW;
                up_ctrl.push = fire && room && in_uplink_reg;
                dn_ctrl.push = fire && room && !in_uplink_reg;
            end
            dqprt_pkg::CMD_SERVICE: begin
                if (up_stat.nonempty || dn_stat.nonempty) begin
                    up_ctrl.pop = fire && pick_up;
                    dn_ctrl.pop = fire && !pick_up;
                    res_desc    = hd;
                    res_uplink  = pick_up;
                    priority if (!in_lost_reg) begin
                        res_status = dqprt_pkg::ST_SENT;
                        sent_next  = sent_reg + 16'd1;
                    end else if (hd.retries < max_retries_reg) begin
                        res_desc.retries = hd.retries + 3'd1;
                        push_desc        = res_desc;
                        room = pick_up ? !up_stat.full_after_pop : !dn_stat.full_after_pop;
                        res_status = room ? dqprt_pkg::ST_REQUEUED
                                          : dqprt_pkg::ST_REQUEUE_OVF;
                        up_ctrl.push = fire && room && pick_up;
                        dn_ctrl.push = fire && room && !pick_up;
                    end else begin
                        res_status = dqprt_pkg::ST_RETRY_DROP;
                    end
                end
            end
            default: ;
        endcase
    end

    dqprt_queue #(.DEPTH(QUEUE_DEPTH)) u_up_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (up_ctrl),
        .wdata   (push_desc),
        .limit   (buffer_limit_reg),
        .stat    (up_stat),
        .head    (up_head)
    );

    dqprt_queue #(.DEPTH(QUEUE_DEPTH)) u_dn_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (dn_ctrl),
        .wdata   (push_desc),
        .limit   (buffer_limit_reg),
        .stat    (dn_stat),
        .head    (dn_head)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            sent_reg         <= '0;
            buffer_limit_reg <= dqprt_pkg::BUFFER_LIMIT_RESET;
            max_retries_reg  <= dqprt_pkg::MAX_RETRIES_RESET;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
                sent_reg      <= sent_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index[0])
                    dqprt_pkg::CFG_BUFFER_LIMIT: buffer_limit_reg <= cfg_data;
                    dqprt_pkg::CFG_MAX_RETRIES:  max_retries_reg  <= cfg_data[2:0];
                    default: ;
                endcase
            end
        end
        if (s_accept) begin
            cmd_reg                  <= s_tuser[0];
            in_desc_reg.id           <= s_tdata[15:0];
            in_desc_reg.size         <= s_tdata[26:16];
            in_desc_reg.priority_val <= s_tdata[29:27];
            in_uplink_reg            <= s_tdata[30];
            in_desc_reg.retries      <= s_tdata[33:31];
            in_lost_reg              <= s_tdata[34];
        end
        if (fire) begin
            out_status_reg <= res_status;
            out_desc_reg   <= res_desc;
            out_uplink_reg <= res_uplink;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {6'd0, sent_reg, out_desc_reg.retries, out_uplink_reg,
                       out_desc_reg.priority_val, out_desc_reg.size, out_desc_reg.id};

    // a service request with both queues empty reports idle
    a_idle_service: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && cmd_reg && !up_stat.nonempty && !dn_stat.nonempty
        |=> m_tuser == dqprt_pkg::ST_IDLE)
        else $error("service on empty queues did not report idle");

    // the sent count advances by one with each sent result
    a_sent_count: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res_status == dqprt_pkg::ST_SENT |=> sent_reg == $past(sent_reg) + 16'd1)
        else $error("sent count did not advance on a sent result");

    // one service pops one queue at most
    a_single_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        !(up_ctrl.pop && dn_ctrl.pop))
        else $error("both queues popped in one cycle");

    // an uplink push never goes past the limit
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        up_ctrl.push |-> (!up_stat.full || (up_ctrl.pop && !up_stat.full_after_pop)))
        else $error("uplink push beyond the buffer limit");

endmodule

FILE: src/dqprt_ram.sv
module dqprt_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/dqprt_queue.sv
module dqprt_queue #(
    parameter int DEPTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  dqprt_pkg::q_ctrl_t ctrl,
    input  dqprt_pkg::desc_t  wdata,
    input  logic [4:0]        limit,
    output dqprt_pkg::q_stat_t stat,
    output dqprt_pkg::desc_t  head
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int CW = (FW > 5) ? FW : 5;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] fill_m1;
    logic          bypass_reg;
    dqprt_pkg::desc_t bypass_data_reg;
    logic [$bits(dqprt_pkg::desc_t)-1:0] rdata;

    function automatic logic [AW-1:0] inc_idx(input logic [AW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + AW'(1);
    endfunction

    assign head_next = ctrl.pop  ? inc_idx(head_reg) : head_reg;
    assign tail_next = ctrl.push ? inc_idx(tail_reg) : tail_reg;
    assign fill_next = fill_reg + FW'(ctrl.push) - FW'(ctrl.pop);
    assign fill_m1   = fill_reg - FW'(1);

    assign stat.nonempty       = (fill_reg != '0);
    assign stat.full           = (fill_reg >= FW'(DEPTH)) || (CW'(fill_reg) >= CW'(limit));
    assign stat.full_after_pop = (fill_m1 >= FW'(DEPTH)) || (CW'(fill_m1) >= CW'(limit));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            tail_reg   <= '0;
            fill_reg   <= '0;
            bypass_reg <= 1'b0;
        end else begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            fill_reg   <= fill_next;
            // forward a write that lands on the entry being prefetched
            bypass_reg <= ctrl.push && (tail_reg == head_next);
        end
        bypass_data_reg <= wdata;
    end

    dqprt_ram #(
        .WIDTH ($bits(dqprt_pkg::desc_t)),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ctrl.push),
        .waddr (tail_reg),
        .wdata (wdata),
        .raddr (head_next),
        .rdata (rdata)
    );

    assign head = bypass_reg ? bypass_data_reg : dqprt_pkg::desc_t'(rdata);

endmodule
